// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wpsd_pkg.sv -----
package wpsd_pkg;

    localparam int BYTE_W   = 8;
    localparam int HEIGHT_W = 9;
    localparam int STYLE_W  = 2;
    localparam int DIVD_W   = 16;
    localparam int QUO_W    = 9;
    localparam int BITS_PER_ROUND = 3;
    localparam int ROUNDS   = QUO_W / BITS_PER_ROUND;
    localparam int RND_W    = 2;
    localparam int JOB_W    = 3;
    localparam int NUM_JOBS = 6;

    localparam logic [STYLE_W-1:0] STYLE_BLUE       = 2'd0;
    localparam logic [STYLE_W-1:0] STYLE_THREE_BAND = 2'd1;
    localparam logic [STYLE_W-1:0] STYLE_RGB        = 2'd2;

    localparam logic [BYTE_W-1:0] BLUE_HEIGHT_MASK = 8'h1f;
    localparam logic [BYTE_W-1:0] BLUE_INTENS_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] BLUE_INTENS_HIGH = 8'd5;

    // Bright and dim colors of the blue style.
    localparam logic [BYTE_W-1:0] BRIGHT_R = 8'd116;
    localparam logic [BYTE_W-1:0] BRIGHT_G = 8'd246;
    localparam logic [BYTE_W-1:0] BRIGHT_B = 8'd244;
    localparam logic [BYTE_W-1:0] DIM_R    = 8'd43;
    localparam logic [BYTE_W-1:0] DIM_G    = 8'd89;
    localparam logic [BYTE_W-1:0] DIM_B    = 8'd255;

    // RGB channel scales, and three-band weights in hundredths.
    localparam logic [BYTE_W-1:0] FRONT_SCALE = 8'd255;
    localparam logic [BYTE_W-1:0] BACK_SCALE  = 8'd191;
    localparam logic [6:0] LOW_WEIGHT  = 7'd49;
    localparam logic [6:0] MID_WEIGHT  = 7'd32;
    localparam logic [6:0] HIGH_WEIGHT = 7'd25;
    localparam logic [6:0] ROUND_HALF  = 7'd50;
    localparam logic [BYTE_W-1:0] HUNDRED = 8'd100;

    localparam logic [JOB_W-1:0] JOBS_RGB   = 3'd6;
    localparam logic [JOB_W-1:0] JOBS_THREE = 3'd3;
    localparam logic [JOB_W-1:0] JOBS_NONE  = 3'd0;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [BYTE_W-1:0] divisor;
    } wpsd_div_ctrl_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } wpsd_div_sts_t;

endpackage

// ----- rtl/wpsd_div.sv -----
// Restoring divider that retires three quotient bits per cycle.
// The caller guarantees the quotient fits in nine bits.
module wpsd_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wpsd_pkg::wpsd_div_ctrl_t ctrl,
    output wpsd_pkg::wpsd_div_sts_t  sts
);

    logic [wpsd_pkg::DIVD_W-1:0]   rem_reg, rem_next;
    logic [wpsd_pkg::DIVD_W:0]     dsh_reg, dsh_next;
    logic [wpsd_pkg::QUO_W-1:0]    quo_reg, quo_next;
    logic [wpsd_pkg::RND_W-1:0]    rnd_reg, rnd_next;
    logic                          busy_reg, busy_next;

    logic [wpsd_pkg::DIVD_W-1:0]         r_step;
    logic [wpsd_pkg::DIVD_W:0]           d_step;
    logic [wpsd_pkg::BITS_PER_ROUND-1:0] bits;
    logic [wpsd_pkg::QUO_W-1:0]          q_step;
    logic                                last_round;

    always_comb begin
        r_step = rem_reg;
        d_step = dsh_reg;
        bits   = '0;
        for (int k = 0; k < wpsd_pkg::BITS_PER_ROUND; k++) begin
            if ({1'b0, r_step} >= d_step) begin
                r_step = r_step - d_step[wpsd_pkg::DIVD_W-1:0];
                bits[wpsd_pkg::BITS_PER_ROUND-1-k] = 1'b1;
            end
            d_step = d_step >> 1;
        end
        q_step = {quo_reg[wpsd_pkg::QUO_W-wpsd_pkg::BITS_PER_ROUND-1:0], bits};
        last_round = busy_reg && (rnd_reg == wpsd_pkg::RND_W'(wpsd_pkg::ROUNDS - 1));
    end

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        rnd_next  = rnd_reg;
        busy_next = busy_reg;
        if (ctrl.start) begin
            rem_next  = ctrl.dividend;
            dsh_next  = {1'b0, ctrl.divisor, {(wpsd_pkg::QUO_W-1){1'b0}}};
            quo_next  = '0;
            rnd_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = r_step;
            dsh_next  = d_step;
            quo_next  = q_step;
            rnd_next  = rnd_reg + 1'b1;
            busy_next = !last_round;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign sts.busy     = busy_reg;
    assign sts.done     = last_round;
    assign sts.quotient = q_step;

endmodule

// ----- rtl/waveform_preview_segment_decoder.sv -----
// Waveform preview segment decoder.
// One segment item enters on the s_ channel (six bytes and a last flag) and
// one decoded item leaves on the m_ channel: heights, front and back colors,
// the running peak height and a copy of the last flag. The style register is
// written through the cfg_ channel, which is always ready; write it only
// while no segment is in flight.
// An accepted segment goes through a prep state, the division state (if any
// divisions are needed) and a done state that loads the output register. The
// input is not ready while a segment is being decoded. The blue style (and
// the unused style code) runs no division; the others use one shared divider
// that retires three quotient bits a cycle: three-band runs three divisions
// by one hundred, rgb runs six divisions by the back height (none if zero).
// When the receiver stalls, a finished item waits in the output register and
// the next segment may still be accepted and decoded; its result is held
// until the output register frees up.
// Reset (synchronous, active low) returns the style to blue, clears the peak
// height and empties the output register.
`include "assert_macros.svh"

module waveform_preview_segment_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wpsd_pkg::STYLE_W-1:0]  cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wpsd_pkg::BYTE_W-1:0]   s_byte_0,
    input  logic [wpsd_pkg::BYTE_W-1:0]   s_byte_1,
    input  logic [wpsd_pkg::BYTE_W-1:0]   s_byte_2,
    input  logic [wpsd_pkg::BYTE_W-1:0]   s_byte_3,
    input  logic [wpsd_pkg::BYTE_W-1:0]   s_byte_4,
    input  logic [wpsd_pkg::BYTE_W-1:0]   s_byte_5,
    input  logic                          s_last_segment,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wpsd_pkg::HEIGHT_W-1:0] m_height_first,
    output logic [wpsd_pkg::HEIGHT_W-1:0] m_height_second,
    output logic [wpsd_pkg::HEIGHT_W-1:0] m_height_third,
    output logic [wpsd_pkg::BYTE_W-1:0]   m_front_red,
    output logic [wpsd_pkg::BYTE_W-1:0]   m_front_green,
    output logic [wpsd_pkg::BYTE_W-1:0]   m_front_blue,
    output logic [wpsd_pkg::BYTE_W-1:0]   m_back_red,
    output logic [wpsd_pkg::BYTE_W-1:0]   m_back_green,
    output logic [wpsd_pkg::BYTE_W-1:0]   m_back_blue,
    output logic [wpsd_pkg::HEIGHT_W-1:0] m_max_height,
    output logic                          m_last_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam int BW = wpsd_pkg::BYTE_W;
    localparam int HW = wpsd_pkg::HEIGHT_W;
    localparam int JW = wpsd_pkg::JOB_W;

    logic [1:0]    state_reg, state_next;
    logic [wpsd_pkg::STYLE_W-1:0] style_reg;
    logic [BW-1:0] b0_reg, b1_reg, b2_reg, b3_reg, b4_reg, b5_reg;
    logic          last_reg;
    logic [JW-1:0] job_reg, job_next;
    logic [wpsd_pkg::QUO_W-1:0] quo_reg [wpsd_pkg::NUM_JOBS];
    logic [HW-1:0] peak_reg;

    logic          m_valid_reg;
    logic [HW-1:0] h1_reg, h2_reg, h3_reg, mx_reg;
    logic [BW-1:0] fr_reg, fg_reg, fb_reg, br_reg, bg_reg, bb_reg;
    logic          last_out_reg;

    wpsd_pkg::wpsd_div_ctrl_t div_ctrl;
    wpsd_pkg::wpsd_div_sts_t  div_sts;

    logic          in_accept;
    logic          out_load;
    logic [BW-1:0] back;
    logic [JW-1:0] njobs;
    logic [JW-1:0] job_sel;
    logic [BW-1:0] level;
    logic [BW-1:0] scale;
    logic [14:0]   sum_low, sum_mid, sum_high;
    logic [14:0]   band_sum;

    logic [HW-1:0] h1, h2, h3, hmax, mx;
    logic [BW-1:0] fr, fg, fb, br, bg, bb;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Back height of the rgb style is the largest of the three levels.
    always_comb begin
        back = b5_reg;
        if (b3_reg > back) begin
            back = b3_reg;
        end
        if (b4_reg > back) begin
            back = b4_reg;
        end
    end

    always_comb begin
        case (style_reg)
            wpsd_pkg::STYLE_RGB:        njobs = (back != '0) ? wpsd_pkg::JOBS_RGB
                                                              : wpsd_pkg::JOBS_NONE;
            wpsd_pkg::STYLE_THREE_BAND: njobs = wpsd_pkg::JOBS_THREE;
            default:                    njobs = wpsd_pkg::JOBS_NONE;
        endcase
    end

    // Three-band sums in hundredths, cumulative from the low band up.
    assign sum_low  = 15'(b2_reg * wpsd_pkg::LOW_WEIGHT);
    assign sum_mid  = sum_low + 15'(b0_reg * wpsd_pkg::MID_WEIGHT);
    assign sum_high = sum_mid + 15'(b1_reg * wpsd_pkg::HIGH_WEIGHT);

    // The first division starts from the prep cycle, each later one in the
    // cycle in which the previous one finishes.
    assign job_sel = (state_reg == ST_PREP) ? '0 : job_reg + 1'b1;

    always_comb begin
        case (job_sel)
            3'd0, 3'd3: level = b3_reg;
            3'd1, 3'd4: level = b4_reg;
            default:    level = b5_reg;
        endcase
        scale = (job_sel < JW'(3)) ? wpsd_pkg::FRONT_SCALE : wpsd_pkg::BACK_SCALE;
        case (job_sel)
            3'd0:    band_sum = sum_low;
            3'd1:    band_sum = sum_mid;
            default: band_sum = sum_high;
        endcase
    end

    always_comb begin
        div_ctrl.start = 1'b0;
        if (style_reg == wpsd_pkg::STYLE_RGB) begin
            div_ctrl.dividend = wpsd_pkg::DIVD_W'(level * scale);
            div_ctrl.divisor  = back;
        end else begin
            div_ctrl.dividend = wpsd_pkg::DIVD_W'(band_sum) +
                                wpsd_pkg::DIVD_W'(wpsd_pkg::ROUND_HALF);
            div_ctrl.divisor  = wpsd_pkg::HUNDRED;
        end
        state_next = state_reg;
        job_next   = job_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                job_next = '0;
                if (njobs != wpsd_pkg::JOBS_NONE) begin
                    div_ctrl.start = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    if (job_reg == njobs - 1'b1) begin
                        state_next = ST_DONE;
                    end else begin
                        div_ctrl.start = 1'b1;
                        job_next = job_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    wpsd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .sts     (div_sts)
    );

    // Assemble the result from the stored quotients and bytes.
    always_comb begin
        h1 = '0; h2 = '0; h3 = '0; hmax = '0;
        fr = '0; fg = '0; fb = '0; br = '0; bg = '0; bb = '0;
        case (style_reg)
            wpsd_pkg::STYLE_BLUE: begin
                h1 = HW'(b0_reg & wpsd_pkg::BLUE_HEIGHT_MASK);
                if ((b1_reg & wpsd_pkg::BLUE_INTENS_MASK) >= wpsd_pkg::BLUE_INTENS_HIGH) begin
                    fr = wpsd_pkg::BRIGHT_R; fg = wpsd_pkg::BRIGHT_G; fb = wpsd_pkg::BRIGHT_B;
                end else begin
                    fr = wpsd_pkg::DIM_R; fg = wpsd_pkg::DIM_G; fb = wpsd_pkg::DIM_B;
                end
                h2 = h1; h3 = h1; hmax = h1;
                br = fr; bg = fg; bb = fb;
            end
            wpsd_pkg::STYLE_RGB: begin
                h1 = HW'(back);
                h2 = HW'(b5_reg);
                h3 = h1;
                hmax = h1;
                if (back != '0) begin
                    fr = quo_reg[0][BW-1:0];
                    fg = quo_reg[1][BW-1:0];
                    fb = quo_reg[2][BW-1:0];
                    br = quo_reg[3][BW-1:0];
                    bg = quo_reg[4][BW-1:0];
                    bb = quo_reg[5][BW-1:0];
                end
            end
            wpsd_pkg::STYLE_THREE_BAND: begin
                h1 = quo_reg[0];
                h2 = quo_reg[1];
                h3 = quo_reg[2];
                hmax = h3;
            end
            default: begin
            end
        endcase
        mx = (hmax > peak_reg) ? hmax : peak_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            job_reg     <= '0;
            style_reg   <= wpsd_pkg::STYLE_BLUE;
            peak_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
            if (cfg_valid && cfg_ready) begin
                style_reg <= cfg_wdata;
            end
            if (out_load) begin
                peak_reg    <= last_reg ? '0 : mx;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            b0_reg   <= s_byte_0;
            b1_reg   <= s_byte_1;
            b2_reg   <= s_byte_2;
            b3_reg   <= s_byte_3;
            b4_reg   <= s_byte_4;
            b5_reg   <= s_byte_5;
            last_reg <= s_last_segment;
        end
        if ((state_reg == ST_DIV) && div_sts.done) begin
            quo_reg[job_reg] <= div_sts.quotient;
        end
        if (out_load) begin
            h1_reg <= h1; h2_reg <= h2; h3_reg <= h3; mx_reg <= mx;
            fr_reg <= fr; fg_reg <= fg; fb_reg <= fb;
            br_reg <= br; bg_reg <= bg; bb_reg <= bb;
            last_out_reg <= last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_height_first  = h1_reg;
    assign m_height_second = h2_reg;
    assign m_height_third  = h3_reg;
    assign m_front_red     = fr_reg;
    assign m_front_green   = fg_reg;
    assign m_front_blue    = fb_reg;
    assign m_back_red      = br_reg;
    assign m_back_green    = bg_reg;
    assign m_back_blue     = bb_reg;
    assign m_max_height    = mx_reg;
    assign m_last_out      = last_out_reg;

    // The divider must be quiet whenever a new item can be taken.
    `ASSERT_IMPLY(a_idle_div_quiet, aclk, aresetn, s_ready, !div_sts.busy, "divider busy while idle")
    // A division only finishes while the sequencer waits for it.
    `ASSERT_IMPLY(a_done_in_div, aclk, aresetn, div_sts.done, state_reg == ST_DIV, "stray divider done")
    // An accepted item always goes to the prep cycle next.
    `ASSERT_NEXT(a_accept_prep, aclk, aresetn, in_accept, state_reg == ST_PREP, "accept not followed by prep")
    // The peak is cleared right after a last segment is delivered.
    `ASSERT_NEXT(a_peak_clear, aclk, aresetn, out_load && last_reg, peak_reg == '0, "peak not cleared")

endmodule
